// ===== sv/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared sizes, register indexes, operation codes and the divider request
// type of the clipped box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

    // Image and window limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 15;

    // Field and counter widths
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DIM_W   = 11;
    localparam int RAD_W   = 4;
    localparam int CFG_W   = 11;
    localparam int PIX_W   = 8;
    localparam int IDX_W   = 2;

    // Line store: a ring of rows, addressed {row mod ring, column}
    localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;
    localparam int RING_W     = $clog2(RING_ROWS);
    localparam int LINE_DEPTH = RING_ROWS * MAX_WIDTH;

    // Sum widths
    localparam int COLSUM_W  = 13;
    localparam int WSUM_W    = 18;
    localparam int TOTAL_W   = 28;
    localparam int AREA_W    = 21;
    localparam int SKIP_W    = 14;
    localparam int SPAN_W    = 6;
    localparam int DIV_CNT_W = $clog2(TOTAL_W);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    // Register reset values
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = 11'd480;
    localparam logic [RAD_W-1:0] RST_WINDOW_RADIUS = 4'd1;

    // Operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Divider request
    typedef struct packed {
        logic                start;
        logic [TOTAL_W-1:0]  dividend;
        logic [AREA_W-1:0]   divisor;
    } div_req_t;

endpackage

// ===== sv/bmf_ram.sv =====
// ----------------------------------------------------------------------------
// bmf_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/bmf_div.sv =====
// ----------------------------------------------------------------------------
// bmf_div
// Restoring unsigned divider, one quotient bit per cycle. Pulses done with
// the quotient held until the next request.
// ----------------------------------------------------------------------------
module bmf_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bmf_pkg::div_req_t            req,
    output logic                         done,
    output logic [bmf_pkg::TOTAL_W-1:0]  quotient
);

    logic                           busy_reg;
    logic [bmf_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [bmf_pkg::AREA_W:0]       rem_reg;
    logic [bmf_pkg::TOTAL_W-1:0]    dvd_reg;
    logic [bmf_pkg::AREA_W-1:0]     dvs_reg;
    logic                           done_reg;

    logic [bmf_pkg::AREA_W:0]       rem_sh;
    logic [bmf_pkg::AREA_W:0]       dvs_ext;
    logic                           fits;

    // Shift in the next dividend bit and trial-subtract
    always_comb
    begin
        rem_sh  = {rem_reg[bmf_pkg::AREA_W-1:0], dvd_reg[bmf_pkg::TOTAL_W-1]};
        dvs_ext = {1'b0, dvs_reg};
        fits    = rem_sh >= dvs_ext;
    end

    // Control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? (rem_sh - dvs_ext) : rem_sh;
                dvd_reg <= {dvd_reg[bmf_pkg::TOTAL_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bmf_pkg::DIV_CNT_W'(bmf_pkg::TOTAL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== sv/box_mean_filter_clipped.sv =====
// A pixel with no output passes S_IDLE and S_PIX (a frame's first also S_LATCH and S_PREP).
// An output item also refreshes column sums, drops the left column and runs the bit-serial
// divider, twice on the frame end. At the first column of a row up to R+1 column sums are
// refreshed; on row 0 each is built from its rows. One item is worked on at a time. The line
// store and column-sum memories each give one read per cycle.
// Reset: asynchronous, clears control and counters; memories are not cleared (row 0 writes fresh).
// ----------------------------------------------------------------------------
// box_mean_filter_clipped
// Streaming box mean filter with the window clipped at the image borders.
// Line store ring in one RAM, per-column vertical sums in a second RAM,
// horizontal running sum in a register, shared serial divider.
// ----------------------------------------------------------------------------
module box_mean_filter_clipped (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bmf_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [bmf_pkg::PIX_W-1:0]     pixel_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bmf_pkg::PIX_W-1:0]     filtered_pixel,
    output logic                          frame_last,
    output logic [bmf_pkg::PIX_W-1:0]     image_mean
);

    typedef enum logic [4:0] {
        S_IDLE, S_LATCH, S_PREP, S_PIX, S_E_INIT,
        S_C_START, S_C_ROWRD, S_C_ROWACC, S_C_CSRD, S_C_CSACC,
        S_C_ADDRD, S_C_ADDACC, S_C_SUBRD, S_C_SUBACC, S_C_DONE,
        S_E_LEFT, S_E_LEFTACC, S_E_DIV, S_E_DIVW, S_E_DIV2, S_E_DIV2W, S_E_OUT
    } state_t;

    state_t state_reg;

    // Configuration and per-frame copies
    logic [bmf_pkg::DIM_W-1:0]    cfg_w_reg, cfg_h_reg, act_w_reg, act_h_reg;
    logic [bmf_pkg::RAD_W-1:0]    cfg_r_reg, act_r_reg;
    logic [bmf_pkg::AREA_W-1:0]   area_tot_reg;
    logic [bmf_pkg::SKIP_W-1:0]   skip_reg;

    // Positions and sums
    logic [bmf_pkg::DIM_W-1:0]    in_row_reg;
    logic [bmf_pkg::COL_W-1:0]    in_col_reg;
    logic [bmf_pkg::ROW_W-1:0]    out_row_reg, rd_row_reg;
    logic [bmf_pkg::COL_W-1:0]    out_col_reg, col_reg;
    logic [bmf_pkg::TOTAL_W-1:0]  total_reg;
    logic [bmf_pkg::COLSUM_W-1:0] acc_reg;
    logic [bmf_pkg::WSUM_W-1:0]   hsum_reg;
    logic [bmf_pkg::PIX_W-1:0]    pix_reg, mean_reg, imean_reg;

    // Output register
    logic                         out_valid_reg, frame_last_reg;
    logic [bmf_pkg::PIX_W-1:0]    filtered_reg, image_mean_reg;

    // Window geometry
    logic [bmf_pkg::DIM_W-1:0]    r_ext, orow_ext, ocol_ext, row_hi, col_hi;
    logic [bmf_pkg::DIM_W-1:0]    or_plus, oc_plus, r0, r1, c0, c1;
    logic [bmf_pkg::DIM_W-1:0]    row_span, col_span, sub_row, left_col, rd_sel;
    logic [2*bmf_pkg::SPAN_W-1:0] area;
    logic                         add_ok, sub_ok, right_ok, left_ok, last, frame_done;
    logic [bmf_pkg::DIM_W-1:0]    in_col_inc;
    logic [2*bmf_pkg::DIM_W-1:0]  wh_prod;
    logic [bmf_pkg::RAD_W+bmf_pkg::DIM_W-1:0] rw_prod;

    // Memory ports
    logic                               line_we;
    logic [$clog2(bmf_pkg::LINE_DEPTH)-1:0] line_waddr, line_raddr;
    logic [bmf_pkg::PIX_W-1:0]          line_rdata;
    logic                               cs_we;
    logic [bmf_pkg::COL_W-1:0]          cs_raddr;
    logic [bmf_pkg::COLSUM_W-1:0]       cs_rdata;

    // Divider
    bmf_pkg::div_req_t                  div_req;
    logic                               div_done;
    logic [bmf_pkg::TOTAL_W-1:0]        div_q;

    // Clipped window bounds of the current output position
    always_comb
    begin
        r_ext    = {{(bmf_pkg::DIM_W-bmf_pkg::RAD_W){1'b0}}, act_r_reg};
        orow_ext = {{(bmf_pkg::DIM_W-bmf_pkg::ROW_W){1'b0}}, out_row_reg};
        ocol_ext = {{(bmf_pkg::DIM_W-bmf_pkg::COL_W){1'b0}}, out_col_reg};
        row_hi   = act_h_reg - 1'b1;
        col_hi   = act_w_reg - 1'b1;
        or_plus  = orow_ext + r_ext;
        oc_plus  = ocol_ext + r_ext;
        r0       = (orow_ext >= r_ext) ? (orow_ext - r_ext) : '0;
        c0       = (ocol_ext >= r_ext) ? (ocol_ext - r_ext) : '0;
        r1       = (or_plus < row_hi) ? or_plus : row_hi;
        c1       = (oc_plus < col_hi) ? oc_plus : col_hi;
        row_span = r1 - r0 + 1'b1;
        col_span = c1 - c0 + 1'b1;
        area     = row_span[bmf_pkg::SPAN_W-1:0] * col_span[bmf_pkg::SPAN_W-1:0];
        add_ok   = or_plus <= row_hi;
        sub_ok   = orow_ext > r_ext;
        sub_row  = orow_ext - r_ext - 1'b1;
        right_ok = oc_plus <= col_hi;
        left_ok  = ocol_ext > r_ext;
        left_col = ocol_ext - r_ext - 1'b1;
        last     = (orow_ext == row_hi) && (ocol_ext == col_hi);
        frame_done = in_row_reg >= act_h_reg;
        in_col_inc = {1'b0, in_col_reg} + 1'b1;
        wh_prod  = act_w_reg * act_h_reg;
        rw_prod  = act_r_reg * act_w_reg;
    end

    // Line store row select for the read in flight
    always_comb
    begin
        case (state_reg)
            S_C_ADDRD: rd_sel = or_plus;
            S_C_SUBRD: rd_sel = sub_row;
            default:   rd_sel = {{(bmf_pkg::DIM_W-bmf_pkg::ROW_W){1'b0}}, rd_row_reg};
        endcase
    end

    // Memory addressing
    assign line_we    = (state_reg == S_PIX) && !frame_done;
    assign line_waddr = {in_row_reg[bmf_pkg::RING_W-1:0], in_col_reg};
    assign line_raddr = {rd_sel[bmf_pkg::RING_W-1:0], col_reg};
    assign cs_we      = state_reg == S_C_DONE;
    assign cs_raddr   = (state_reg == S_E_LEFT) ? left_col[bmf_pkg::COL_W-1:0] : col_reg;

    // Divider requests: window mean, then image mean on the frame end
    always_comb
    begin
        div_req.start    = (state_reg == S_E_DIV) || (state_reg == S_E_DIV2);
        div_req.dividend = (state_reg == S_E_DIV2) ? total_reg
                         : {{(bmf_pkg::TOTAL_W-bmf_pkg::WSUM_W){1'b0}}, hsum_reg};
        div_req.divisor  = (state_reg == S_E_DIV2) ? area_tot_reg
                         : {{(bmf_pkg::AREA_W-2*bmf_pkg::SPAN_W){1'b0}}, area};
    end

    bmf_ram #(
        .WIDTH (bmf_pkg::PIX_W),
        .DEPTH (bmf_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (pix_reg),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    bmf_ram #(
        .WIDTH (bmf_pkg::COLSUM_W),
        .DEPTH (bmf_pkg::MAX_WIDTH)
    ) u_colsum_ram (
        .clk   (clk),
        .we    (cs_we),
        .waddr (col_reg),
        .wdata (acc_reg),
        .raddr (cs_raddr),
        .rdata (cs_rdata)
    );

    bmf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_w_reg     <= bmf_pkg::RST_IMAGE_WIDTH;
            cfg_h_reg     <= bmf_pkg::RST_IMAGE_HEIGHT;
            cfg_r_reg     <= bmf_pkg::RST_WINDOW_RADIUS;
            act_w_reg     <= bmf_pkg::RST_IMAGE_WIDTH;
            act_h_reg     <= bmf_pkg::RST_IMAGE_HEIGHT;
            act_r_reg     <= bmf_pkg::RST_WINDOW_RADIUS;
            area_tot_reg  <= '0;
            skip_reg      <= '0;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bmf_pkg::REG_IMAGE_WIDTH:   cfg_w_reg <= cfg_data;
                    bmf_pkg::REG_IMAGE_HEIGHT:  cfg_h_reg <= cfg_data;
                    bmf_pkg::REG_WINDOW_RADIUS: cfg_r_reg <= cfg_data[bmf_pkg::RAD_W-1:0];
                    default: ;
                endcase
            end

            // Drop the output item once taken, unless the next one is loaded now
            if (out_valid_reg && !out_stall && (state_reg != S_E_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        pix_reg <= pixel_value;
                        if (operation == bmf_pkg::OP_DRAIN)
                        begin
                            if (frame_done)
                            begin
                                state_reg <= S_E_INIT;
                            end
                        end
                        else if ((in_row_reg == '0) && (in_col_reg == '0))
                        begin
                            state_reg <= S_LATCH;
                        end
                        else
                        begin
                            state_reg <= S_PIX;
                        end
                    end
                end

                // Take the frame's geometry
                S_LATCH:
                begin
                    act_w_reg <= (cfg_w_reg == '0) ? bmf_pkg::DIM_W'(1)
                               : (cfg_w_reg > bmf_pkg::DIM_W'(bmf_pkg::MAX_WIDTH))
                                 ? bmf_pkg::DIM_W'(bmf_pkg::MAX_WIDTH) : cfg_w_reg;
                    act_h_reg <= (cfg_h_reg == '0) ? bmf_pkg::DIM_W'(1)
                               : (cfg_h_reg > bmf_pkg::DIM_W'(bmf_pkg::MAX_HEIGHT))
                                 ? bmf_pkg::DIM_W'(bmf_pkg::MAX_HEIGHT) : cfg_h_reg;
                    act_r_reg <= (cfg_r_reg > bmf_pkg::RAD_W'(bmf_pkg::MAX_RADIUS))
                                 ? bmf_pkg::RAD_W'(bmf_pkg::MAX_RADIUS) : cfg_r_reg;
                    state_reg <= S_PREP;
                end

                S_PREP:
                begin
                    area_tot_reg <= wh_prod[bmf_pkg::AREA_W-1:0];
                    skip_reg     <= bmf_pkg::SKIP_W'(rw_prod)
                                  + {{(bmf_pkg::SKIP_W-bmf_pkg::RAD_W){1'b0}}, act_r_reg};
                    out_row_reg  <= '0;
                    out_col_reg  <= '0;
                    total_reg    <= '0;
                    state_reg    <= S_PIX;
                end

                // Store the pixel, advance the input position
                S_PIX:
                begin
                    if (frame_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        total_reg <= total_reg
                                   + {{(bmf_pkg::TOTAL_W-bmf_pkg::PIX_W){1'b0}}, pix_reg};
                        if (in_col_inc >= act_w_reg)
                        begin
                            in_col_reg <= '0;
                            in_row_reg <= in_row_reg + 1'b1;
                        end
                        else
                        begin
                            in_col_reg <= in_col_inc[bmf_pkg::COL_W-1:0];
                        end
                        if (skip_reg == '0)
                        begin
                            state_reg <= S_E_INIT;
                        end
                        else
                        begin
                            skip_reg  <= skip_reg - 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end

                // Pick the columns entering the window
                S_E_INIT:
                begin
                    if (out_col_reg == '0)
                    begin
                        hsum_reg  <= '0;
                        col_reg   <= '0;
                        state_reg <= S_C_START;
                    end
                    else if (right_ok)
                    begin
                        col_reg   <= oc_plus[bmf_pkg::COL_W-1:0];
                        state_reg <= S_C_START;
                    end
                    else
                    begin
                        state_reg <= S_E_LEFT;
                    end
                end

                S_C_START:
                begin
                    if (out_row_reg == '0)
                    begin
                        acc_reg    <= '0;
                        rd_row_reg <= '0;
                        state_reg  <= S_C_ROWRD;
                    end
                    else
                    begin
                        state_reg <= S_C_CSRD;
                    end
                end

                // Top row: build the column sum from its rows
                S_C_ROWRD:  state_reg <= S_C_ROWACC;
                S_C_ROWACC:
                begin
                    acc_reg <= acc_reg
                             + {{(bmf_pkg::COLSUM_W-bmf_pkg::PIX_W){1'b0}}, line_rdata};
                    if (rd_row_reg == r1[bmf_pkg::ROW_W-1:0])
                    begin
                        state_reg <= S_C_DONE;
                    end
                    else
                    begin
                        rd_row_reg <= rd_row_reg + 1'b1;
                        state_reg  <= S_C_ROWRD;
                    end
                end

                // Later rows: slide the column sum down by one row
                S_C_CSRD:   state_reg <= S_C_CSACC;
                S_C_CSACC:
                begin
                    acc_reg <= cs_rdata;
                    if (add_ok)
                    begin
                        state_reg <= S_C_ADDRD;
                    end
                    else if (sub_ok)
                    begin
                        state_reg <= S_C_SUBRD;
                    end
                    else
                    begin
                        state_reg <= S_C_DONE;
                    end
                end
                S_C_ADDRD:  state_reg <= S_C_ADDACC;
                S_C_ADDACC:
                begin
                    acc_reg   <= acc_reg
                               + {{(bmf_pkg::COLSUM_W-bmf_pkg::PIX_W){1'b0}}, line_rdata};
                    state_reg <= sub_ok ? S_C_SUBRD : S_C_DONE;
                end
                S_C_SUBRD:  state_reg <= S_C_SUBACC;
                S_C_SUBACC:
                begin
                    acc_reg   <= acc_reg
                               - {{(bmf_pkg::COLSUM_W-bmf_pkg::PIX_W){1'b0}}, line_rdata};
                    state_reg <= S_C_DONE;
                end

                // Write back the column sum, add it to the window
                S_C_DONE:
                begin
                    hsum_reg <= hsum_reg
                              + {{(bmf_pkg::WSUM_W-bmf_pkg::COLSUM_W){1'b0}}, acc_reg};
                    if ((out_col_reg == '0) && (col_reg < c1[bmf_pkg::COL_W-1:0]))
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= S_C_START;
                    end
                    else
                    begin
                        state_reg <= S_E_LEFT;
                    end
                end

                // Remove the column leaving the window
                S_E_LEFT:   state_reg <= left_ok ? S_E_LEFTACC : S_E_DIV;
                S_E_LEFTACC:
                begin
                    hsum_reg  <= hsum_reg
                               - {{(bmf_pkg::WSUM_W-bmf_pkg::COLSUM_W){1'b0}}, cs_rdata};
                    state_reg <= S_E_DIV;
                end

                S_E_DIV:    state_reg <= S_E_DIVW;
                S_E_DIVW:
                begin
                    if (div_done)
                    begin
                        mean_reg <= div_q[bmf_pkg::PIX_W-1:0];
                        if (last)
                        begin
                            state_reg <= S_E_DIV2;
                        end
                        else
                        begin
                            imean_reg <= '0;
                            state_reg <= S_E_OUT;
                        end
                    end
                end
                S_E_DIV2:   state_reg <= S_E_DIV2W;
                S_E_DIV2W:
                begin
                    if (div_done)
                    begin
                        imean_reg <= div_q[bmf_pkg::PIX_W-1:0];
                        state_reg <= S_E_OUT;
                    end
                end

                // Hand over the item once the output register is free
                S_E_OUT:
                begin
                    if (!(out_valid_reg && out_stall))
                    begin
                        out_valid_reg  <= 1'b1;
                        filtered_reg   <= mean_reg;
                        frame_last_reg <= last;
                        image_mean_reg <= imean_reg;
                        if (last)
                        begin
                            in_row_reg <= '0;
                            in_col_reg <= '0;
                        end
                        else if (ocol_ext == col_hi)
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 1'b1;
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall       = state_reg != S_IDLE;
    assign out_valid      = out_valid_reg;
    assign filtered_pixel = filtered_reg;
    assign frame_last     = frame_last_reg;
    assign image_mean     = image_mean_reg;

endmodule

// ===== sv/bmf_checker.sv =====
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks of the clipped box mean filter, bound to the top level.
// ----------------------------------------------------------------------------
module bmf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [bmf_pkg::PIX_W-1:0]     filtered_pixel,
    input logic                          frame_last,
    input logic [bmf_pkg::PIX_W-1:0]     image_mean
);

    // Hold a stalled output item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(filtered_pixel) && $stable(frame_last)
                                   && $stable(image_mean))
        else $error("stalled output item changed");

    // Image mean only on the frame end
    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_last |-> image_mean == '0)
        else $error("image mean set on a non-final item");

    // Handshake outputs always driven to known levels
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid}))
        else $error("handshake output unknown");

endmodule

bind box_mean_filter_clipped bmf_checker u_bmf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_pixel (filtered_pixel),
    .frame_last     (frame_last),
    .image_mean     (image_mean)
);
